// ----- design/msm_pkg.sv -----
// Package for masked_softmax: shared types, exp table constants, item structs.
// No dependencies.
package msm_pkg;

  localparam int unsigned LogitW = 16;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned SumW   = 25;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned AccW   = 31;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [AccW-1:0] Q30One = 31'd1073741824;

  typedef enum logic {
    ActLoad = 1'b0,
    ActRead = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [IdxW-1:0]  index;
    logic [LogitW-1:0] logit;
    logic             legal;
  } in_item_t;

  typedef struct packed {
    logic [ProbW-1:0] probability;
    logic             none_legal;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StMaxRd, StMaxAcc, StSumRd, StExp, StSumAcc,
    StRdMem, StRdExp, StDiv, StOut
  } back_state_e;

  function automatic logic [29:0] exp_factor(input logic [3:0] k);
    logic [29:0] f;
    case (k)
      4'd0:  f = 30'd1069555701;
      4'd1:  f = 30'd1065385899;
      4'd2:  f = 30'd1057095000;
      4'd3:  f = 30'd1040706261;
      4'd4:  f = 30'd1008687096;
      4'd5:  f = 30'd947573834;
      4'd6:  f = 30'd836230973;
      4'd7:  f = 30'd651257337;
      4'd8:  f = 30'd395007542;
      4'd9:  f = 30'd145315154;
      4'd10: f = 30'd19666268;
      4'd11: f = 30'd360200;
      default: f = 30'd0;
    endcase
    return f;
  endfunction

endpackage

// ----- design/msm_stream_if.sv -----
// Valid/ready channel interface for masked_softmax items.
// Depends on nothing; payload type is a parameter.
interface msm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/msm_queue.sv -----
// Two-entry item queue between front and back of masked_softmax.
// Depends on msm_pkg.
module msm_queue import msm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t push_item_i,
  output logic     full_o,
  input  logic     pop_i,
  output in_item_t pop_item_o,
  output logic     empty_o
);
  in_item_t  slot_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_item_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
endmodule

// ----- design/msm_front.sv -----
// Front of masked_softmax: accepts items, drops out-of-range loads, feeds queue.
// Depends on msm_pkg and msm_stream_if.
module msm_front import msm_pkg::*; #(
  parameter int unsigned NUM_ACTIONS = 256
) (
  msm_stream_if.sink in_s,
  input  logic     q_full_i,
  output logic     push_o,
  output in_item_t push_item_o
);
  logic in_range;
  assign in_range    = 32'(in_s.payload.index) < NUM_ACTIONS;
  assign in_s.ready  = !q_full_i;
  // drop loads aimed past the store
  assign push_o      = in_s.valid && !q_full_i &&
                       (in_s.payload.action == ActRead || in_range);
  assign push_item_o = in_s.payload;
endmodule

// ----- design/msm_back.sv -----
// Back of masked_softmax: logit store, max/sum walk, exp unit, divider, output.
// Depends on msm_pkg and msm_stream_if.
module msm_back import msm_pkg::*; #(
  parameter int unsigned NUM_ACTIONS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  in_item_t q_item_i,
  output logic     pop_o,
  msm_stream_if.source out_s
);
  localparam int unsigned AW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int unsigned CW = AW + 1;

  logic [LogitW-1:0] store_mem [NUM_ACTIONS];
  logic [NUM_ACTIONS-1:0] legal_q;
  logic [LogitW-1:0] rd_data_q;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic [AW-1:0] q_idx;

  back_state_e state_q, state_d;
  logic [CW-1:0] walk_q, walk_d;
  logic [LogitW-1:0] top_q, top_d;
  logic any_q, any_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic stale_q, stale_d;
  logic cur_legal_q, cur_legal_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic rlegal_q, rlegal_d;

  // exp unit: one factor multiply per cycle
  logic [AccW-1:0] acc_q, acc_d;
  logic [3:0] estep_q, estep_d;
  logic [11:0] ebits_q, ebits_d;
  logic [16:0] mag;
  logic [AccW+29:0] prod;
  logic [AccW-1:0] prod_rnd;
  logic [17:0] e_rnd;
  logic [ProbW-1:0] e_val;

  // restoring divider
  logic [SumW+1:0] rem_q, rem_d;
  logic [32:0] dvd_q, dvd_d;
  logic [5:0] dcnt_q, dcnt_d;
  logic [32:0] quo_q, quo_d;
  logic [SumW+1:0] rem_sh;

  out_item_t res_q, res_d;
  logic ovalid_q, ovalid_d;

  assign out_s.valid   = ovalid_q;
  assign out_s.payload = res_q;

  assign q_idx    = AW'(q_item_i.index);
  assign mag      = 17'($signed({top_q[LogitW-1], top_q}) -
                        $signed({rd_data_q[LogitW-1], rd_data_q}));
  assign prod     = (AccW+30)'(acc_q) * (AccW+30)'(exp_factor(estep_q)) +
                    (AccW+30)'(30'd536870912);
  assign prod_rnd = prod[AccW+29:30];
  assign e_rnd    = 18'((acc_q + AccW'(8192)) >> 14);
  assign e_val    = (e_rnd > 18'd65535) ? 16'hFFFF : e_rnd[15:0];
  assign rem_sh   = {rem_q[SumW:0], dvd_q[32]};

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.action == ActLoad)
      store_mem[q_idx] <= q_item_i.logit;
    if (rd_en) rd_data_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      legal_q  <= '0;
      stale_q  <= 1'b1;
      top_q    <= '0;
      sum_q    <= '0;
      any_q    <= 1'b0;
      ovalid_q <= 1'b0;
      walk_q   <= '0;
    end else begin
      state_q  <= state_d;
      stale_q  <= stale_d;
      top_q    <= top_d;
      sum_q    <= sum_d;
      any_q    <= any_d;
      ovalid_q <= ovalid_d;
      walk_q   <= walk_d;
      if (pop_o && q_item_i.action == ActLoad)
        legal_q[q_idx] <= q_item_i.legal;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_legal_q <= cur_legal_d;
    ridx_q      <= ridx_d;
    rlegal_q    <= rlegal_d;
    acc_q       <= acc_d;
    estep_q     <= estep_d;
    ebits_q     <= ebits_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    dcnt_q      <= dcnt_d;
    quo_q       <= quo_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d = state_q;  walk_d = walk_q;  top_d = top_q;  any_d = any_q;
    sum_d = sum_q;  stale_d = stale_q;  cur_legal_d = cur_legal_q;
    ridx_d = ridx_q;  rlegal_d = rlegal_q;  acc_d = acc_q;
    estep_d = estep_q;  ebits_d = ebits_q;  rem_d = rem_q;  dvd_d = dvd_q;
    dcnt_d = dcnt_q;  quo_d = quo_q;  res_d = res_q;  ovalid_d = ovalid_q;
    pop_o = 1'b0;  rd_en = 1'b0;  rd_addr = walk_q[AW-1:0];
    if (ovalid_q && out_s.ready) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          if (q_item_i.action == ActLoad) begin
            pop_o = 1'b1;
            stale_d = 1'b1;
          end else if (!ovalid_q || out_s.ready) begin
            pop_o = 1'b1;
            ridx_d = q_idx;
            rlegal_d = (32'(q_item_i.index) < NUM_ACTIONS) &&
                       legal_q[q_idx];
            walk_d = '0;
            any_d = stale_q ? 1'b0 : any_q;
            state_d = stale_q ? StMaxRd : StRdMem;
          end
        end
      end
      StMaxRd: begin
        rd_en = 1'b1;
        cur_legal_d = legal_q[walk_q[AW-1:0]];
        state_d = StMaxAcc;
      end
      StMaxAcc: begin
        if (cur_legal_q && (!any_q || $signed(rd_data_q) > $signed(top_q))) begin
          top_d = rd_data_q;
        end
        if (cur_legal_q) any_d = 1'b1;
        if (walk_q == CW'(NUM_ACTIONS - 1)) begin
          walk_d = '0;
          sum_d = '0;
          if (!(any_q || cur_legal_q)) top_d = '0;
          state_d = StSumRd;
        end else begin
          walk_d = walk_q + 1'b1;
          state_d = StMaxRd;
        end
      end
      StSumRd: begin
        rd_en = 1'b1;
        cur_legal_d = legal_q[walk_q[AW-1:0]];
        state_d = StExp;
        estep_d = 4'd0;
        acc_d = Q30One;
      end
      StExp: begin
        if (estep_q == 4'd0) ebits_d = {mag[11:8], mag[7:0]};
        if (estep_q == 4'd0 && (mag[16:12] != 5'd0 || !cur_legal_q)) begin
          acc_d = '0;
          estep_d = 4'd12;
        end else if (estep_q == 4'd12) begin
          state_d = StSumAcc;
        end else begin
          if ((estep_q == 4'd0) ? mag[0] : ebits_q[estep_q]) acc_d = prod_rnd;
          estep_d = estep_q + 4'd1;
        end
      end
      StSumAcc: begin
        if (cur_legal_q)
          sum_d = ({1'b0, sum_q} + {10'd0, e_val} > {1'b0, SumMax}) ? SumMax :
                  sum_q + SumW'(e_val);
        if (walk_q == CW'(NUM_ACTIONS - 1)) begin
          stale_d = 1'b0;
          state_d = StRdMem;
        end else begin
          walk_d = walk_q + 1'b1;
          state_d = StSumRd;
        end
      end
      StRdMem: begin
        rd_en = 1'b1;
        rd_addr = ridx_q;
        cur_legal_d = rlegal_q;
        estep_d = 4'd0;
        acc_d = Q30One;
        state_d = StRdExp;
      end
      StRdExp: begin
        if (estep_q == 4'd0) ebits_d = {mag[11:8], mag[7:0]};
        if (estep_q == 4'd0 && (mag[16:12] != 5'd0 || !cur_legal_q)) begin
          acc_d = '0;
          estep_d = 4'd12;
        end else if (estep_q == 4'd12) begin
          // dividend e<<16 plus half the sum, rounded quotient
          dvd_d = 33'({e_val, 16'd0}) + 33'(sum_q >> 1);
          rem_d = '0;
          quo_d = '0;
          dcnt_d = 6'd33;
          state_d = StDiv;
        end else begin
          if ((estep_q == 4'd0) ? mag[0] : ebits_q[estep_q]) acc_d = prod_rnd;
          estep_d = estep_q + 4'd1;
        end
      end
      StDiv: begin
        if (rem_sh >= {2'b0, sum_q} && sum_q != '0) begin
          rem_d = rem_sh - {2'b0, sum_q};
          quo_d = {quo_q[31:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[31:0], 1'b0};
        end
        dvd_d = {dvd_q[31:0], 1'b0};
        dcnt_d = dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) state_d = StOut;
      end
      StOut: begin
        res_d.none_legal = sum_q == '0;
        if (!cur_legal_q || sum_q == '0) res_d.probability = '0;
        else res_d.probability = (quo_q > 33'd65535) ? 16'hFFFF : quo_q[15:0];
        ovalid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> ovalid_q)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSumAcc && state_d == StRdMem) |=> !stale_q)
    else $error("sums still stale after walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == StIdle)
    else $error("queue popped while busy");
endmodule

// ----- design/masked_softmax.sv -----
// Top level of masked_softmax: front, queue and back joined by channels.
// Depends on msm_pkg, msm_stream_if, msm_front, msm_queue, msm_back.
//
// A read on fresh sums runs the 13-step exp unit and then the 33-step
// divider. The first read after any load first walks the logit store twice
// over its single read port, passing each slot through the serial exp unit.
// Results wait in an output register; a two-item queue lets the front keep
// accepting.
module masked_softmax import msm_pkg::*; #(
  parameter int unsigned NUM_ACTIONS = 256
) (
  input logic clk_i,
  input logic rst_ni,
  msm_stream_if.sink   in_s,
  msm_stream_if.source out_s
);
  logic     push, q_full, q_empty, pop;
  in_item_t push_item, pop_item;

  msm_front #(.NUM_ACTIONS(NUM_ACTIONS)) u_front (
    .in_s(in_s), .q_full_i(q_full), .push_o(push), .push_item_o(push_item)
  );

  msm_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .push_item_i(push_item),
    .full_o(q_full), .pop_i(pop), .pop_item_o(pop_item), .empty_o(q_empty)
  );

  msm_back #(.NUM_ACTIONS(NUM_ACTIONS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_empty_i(q_empty), .q_item_i(pop_item),
    .pop_o(pop), .out_s(out_s)
  );
endmodule
